[hw/rtl/aspld_pkg.sv]
// Shared types for the AS path loop detector: controller states and control/status bundles.
package aspld_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // latch the input beat, restart the scan
    logic rd_en;   // read the next stored number
    logic commit;  // store the number, update flags, emit verdict on last
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_scan;  // number differs from previous, store not empty, no loop yet
    logic scan_more;  // stored entries remain to be read
    logic scan_done;  // all reads issued and compared
    logic loop_set;   // loop already known for this path
    logic last;       // latched beat closes the path
    logic out_free;   // result register can take a verdict this cycle
  } status_t;

endpackage

[hw/rtl/aspld_ctrl.sv]
// Controller state machine: sequences accept, store scan and commit for each beat.
module aspld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aspld_pkg::status_t sts_i,
  output aspld_pkg::cmd_t    cmd_o
);

  aspld_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aspld_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      aspld_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = aspld_pkg::ST_CHECK;
        end
      end
      aspld_pkg::ST_CHECK: begin
        if (sts_i.need_scan) begin
          state_d = aspld_pkg::ST_SCAN;
        end else begin
          state_d = aspld_pkg::ST_COMMIT;
        end
      end
      aspld_pkg::ST_SCAN: begin
        // stop early once a loop is seen
        cmd_o.rd_en = sts_i.scan_more && !sts_i.loop_set;
        if (sts_i.loop_set || sts_i.scan_done) begin
          state_d = aspld_pkg::ST_COMMIT;
        end
      end
      aspld_pkg::ST_COMMIT: begin
        // hold while a verdict is due and the result register is busy
        if (!sts_i.last || sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = aspld_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = aspld_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/aspld_dp.sv]
// Datapath: number store, scan compare, path flags and the result register.
module aspld_dp #(
  parameter int MAX_PATH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        asn_i,
  input  logic               last_i,
  input  aspld_pkg::cmd_t     cmd_i,
  output aspld_pkg::status_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               loop_found_o,
  output logic               overflow_o
);

  localparam int CW = $clog2(MAX_PATH + 1);
  localparam int AW = $clog2(MAX_PATH);
  localparam logic [CW-1:0] FullCount = CW'(MAX_PATH);

  // Store of the numbers seen in this path
  logic [31:0] mem_q [MAX_PATH];

  // Latched beat
  logic [31:0] asn_q;
  logic        last_q;

  // Path state
  logic [31:0]   prev_q;
  logic [CW-1:0] count_q;
  logic          loop_q;
  logic          ovf_q;

  // Scan state
  logic [CW-1:0] idx_q;
  logic          rd_vld_q;
  logic [31:0]   rd_data_q;

  // Result register
  logic out_vld_q;
  logic out_loop_q;
  logic out_ovf_q;

  logic store_full;
  logic hit;

  assign store_full = (count_q == FullCount);
  assign hit        = rd_vld_q && (rd_data_q == asn_q);

  // Status to controller
  assign sts_o.need_scan = (count_q != '0) && (asn_q != prev_q) && !loop_q;
  assign sts_o.scan_more = (idx_q < count_q);
  assign sts_o.scan_done = !(idx_q < count_q) && !rd_vld_q;
  assign sts_o.loop_set  = loop_q;
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  // Input beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      asn_q  <= asn_i;
      last_q <= last_i;
    end
  end

  // Store write on commit, registered read during scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !store_full) begin
      mem_q[count_q[AW-1:0]] <= asn_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  // Scan index and read-valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.accept || cmd_i.commit) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  // Path flags, count and previous number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      count_q <= '0;
      loop_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      if (last_q) begin
        prev_q  <= '0;
        count_q <= '0;
        loop_q  <= 1'b0;
        ovf_q   <= 1'b0;
      end else begin
        prev_q <= asn_q;
        if (store_full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
    end else if (hit) begin
      loop_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.commit && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && last_q) begin
      out_loop_q <= loop_q;
      out_ovf_q  <= ovf_q || store_full;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign loop_found_o = out_loop_q;
  assign overflow_o   = out_ovf_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("stored count beyond capacity");

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && last_q |-> !out_vld_q || out_ready_i)
    else $error("verdict committed into a busy result register");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> idx_q < count_q)
    else $error("store read past the stored entries");

  a_flags_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && last_q |=> count_q == '0 && !loop_q && !ovf_q)
    else $error("path state not cleared after last beat");

endmodule

[hw/rtl/as_path_loop_detector_unit.sv]
// Top level of the AS path loop detector: controller plus datapath.
//
//  channel  dir  tdata fields (low bit up)            side band
//  s_axis   in   asn[31:0]                            tlast = last
//  m_axis   out  loop_found[0], overflow[1], 0[7:2]   -
//
// A beat skips the scan when the number repeats the previous one, the store is
// empty or a loop is already known; otherwise the n stored numbers are read
// through the single read port of the store, scanned one entry a cycle (the scan
// ends early on a match). Reset clears all control state; no clearing pass.
// A verdict waits in the result register while m_axis stalls; the next beats are
// still accepted, and only a later path end holds until the verdict is taken.
module as_path_loop_detector_unit #(
  parameter int MAX_PATH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // asn[31:0]
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // loop_found[0], overflow[1], zero[7:2]
);

  aspld_pkg::cmd_t    cmd;
  aspld_pkg::status_t sts;
  logic               loop_found;
  logic               overflow;

  aspld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aspld_dp #(
    .MAX_PATH (MAX_PATH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .asn_i        (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .loop_found_o (loop_found),
    .overflow_o   (overflow)
  );

  // Result beat packing
  assign m_axis_tdata = {6'b0, overflow, loop_found};

endmodule

[tb/testbench.sv]
// Testbench for the AS path loop detector: random path streams checked against a path predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_PATH  = 64;
  localparam int NUM_ITEMS = 1100;
  localparam int LIMIT     = 600000;

  // One input beat plus a flag that holds it back until all verdicts are in
  typedef struct {
    logic [31:0] asn;
    logic        last;
    logic        hold;
  } path_beat_t;

  typedef struct packed {
    logic loop_found;
    logic overflow;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // asn[31:0]
  logic        s_axis_tlast = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // loop_found[0], overflow[1], zero[7:2]

  path_beat_t  beats_to_send[$];
  verdict_t    pending_verdicts[$];
  int          err_count = 0;
  int          cycle_count = 0;
  logic        s_beat = 1'b0;

  // Predictor state for the current path
  logic [31:0] path_store[MAX_PATH];
  int          path_len = 0;
  logic [31:0] prev_asn = '0;
  logic        loop_seen = 1'b0;
  logic        ovf_seen = 1'b0;

  // Sender and receiver pacing
  int          burst_left = 8;
  int          gap_left = 0;
  int          rx_left = 0;
  int          rx_mode = 0;

  as_path_loop_detector_unit #(
    .MAX_PATH(MAX_PATH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic void queue_beat(logic [31:0] asn, logic last, logic hold);
    path_beat_t b;
    b.asn  = asn;
    b.last = last;
    b.hold = hold;
    beats_to_send = {beats_to_send, b};
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  // Fold one accepted number into the path state; queue a verdict on last
  task automatic track_path_number(input logic [31:0] asn, input logic last);
    logic     hit;
    verdict_t v;
    hit = 1'b0;
    for (int k = 0; k < path_len; k++)
      if (path_store[k] == asn) hit = 1'b1;
    // a repeat counts only when something else came in between
    if (path_len > 0 && asn != prev_asn && hit) loop_seen = 1'b1;
    if (path_len < MAX_PATH) begin
      path_store[path_len] = asn;
      path_len++;
    end else begin
      ovf_seen = 1'b1;
    end
    prev_asn = asn;
    if (last) begin
      v.loop_found = loop_seen;
      v.overflow   = ovf_seen;
      pending_verdicts = {pending_verdicts, v};
      path_len  = 0;
      prev_asn  = '0;
      loop_seen = 1'b0;
      ovf_seen  = 1'b0;
    end
  endtask

  // Sender: bursts of beats with random gaps; a held beat waits for a drained pipe
  always @(negedge clk_i) begin : driver
    path_beat_t nxt;
    if (rst_ni && !(s_axis_tvalid && !s_beat)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (beats_to_send.size() != 0 &&
                   !(beats_to_send[0].hold && pending_verdicts.size() != 0)) begin
        nxt = beats_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.asn;
        s_axis_tlast  <= nxt.last;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10);
          end
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between always ready, coin flip and long stalls
  always @(negedge clk_i) begin : receiver
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Monitor: predicts on accepted input beats, checks verdict beats
  always @(posedge clk_i) begin : monitor
    verdict_t want;
    if (!rst_ni) begin
      s_beat <= 1'b0;
    end else begin
      s_beat <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) track_path_number(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected verdict", m_axis_tdata, 8'h00);
        end else begin
          want = pending_verdicts.pop_front();
          if (m_axis_tdata[0] !== want.loop_found)
            report_mismatch("loop_found", 8'(m_axis_tdata[0]), 8'(want.loop_found));
          if (m_axis_tdata[1] !== want.overflow)
            report_mismatch("overflow", 8'(m_axis_tdata[1]), 8'(want.overflow));
          if (m_axis_tdata[7:2] !== 6'd0)
            report_mismatch("padding", 8'(m_axis_tdata[7:2]), 8'h00);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int          total;
    int          plen;
    int          pmode;
    int          r;
    logic [31:0] v;
    logic [31:0] path_vals[$];

    // Directed paths
    queue_beat(32'h0000_0000, 1'b1, 1'b0);          // single number, zero
    queue_beat(32'hFFFF_FFFF, 1'b1, 1'b0);          // single number, all ones
    queue_beat(32'd5, 1'b0, 1'b0);                  // prepending only
    queue_beat(32'd5, 1'b0, 1'b0);
    queue_beat(32'd5, 1'b1, 1'b0);
    queue_beat(32'd7, 1'b0, 1'b0);                  // simple loop
    queue_beat(32'd9, 1'b0, 1'b0);
    queue_beat(32'd7, 1'b1, 1'b0);
    queue_beat(32'hAAAA_AAAA, 1'b0, 1'b0);          // adjacent repeat at the end
    queue_beat(32'h5555_5555, 1'b0, 1'b0);
    queue_beat(32'h5555_5555, 1'b1, 1'b0);
    queue_beat(32'd1, 1'b0, 1'b0);                  // loop after a prepend
    queue_beat(32'd2, 1'b0, 1'b0);
    queue_beat(32'd2, 1'b0, 1'b0);
    queue_beat(32'd1, 1'b1, 1'b0);
    queue_beat(32'h0000_0000, 1'b0, 1'b0);          // loop between the extremes
    queue_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
    queue_beat(32'h0000_0000, 1'b0, 1'b0);
    queue_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
    queue_beat(32'h0000_0000, 1'b1, 1'b1);          // zero first after a cleared path

    // Random paths: mostly short, a few past the store capacity
    total = 0;
    while (total < NUM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      plen = $urandom_range(1, 10);
      else if (r < 90) plen = $urandom_range(11, 40);
      else             plen = $urandom_range(MAX_PATH - 4, MAX_PATH + 8);
      pmode = $urandom_range(0, 2);   // 0: loop free apart from collisions
      path_vals.delete();
      for (int i = 0; i < plen; i++) begin
        r = $urandom_range(0, 99);
        if (i > 0 && r < 25) begin
          v = path_vals[i - 1];
        end else if (i > 0 && pmode != 0 && r < 45) begin
          v = path_vals[$urandom_range(0, i - 1)];
        end else begin
          case ($urandom_range(0, 9))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom_range(0, 15);
            default: v = $urandom;
          endcase
        end
        // long clean path: a repeat of the first number once the store is full
        if (pmode == 0 && plen > MAX_PATH && i == plen - 1 && $urandom_range(0, 1) == 1)
          v = path_vals[0];
        path_vals = {path_vals, v};
        queue_beat(v, i == plen - 1, i == 0 && $urandom_range(0, 14) == 0);
      end
      total += plen;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all beats taken, all verdicts in, then a quiet stretch
    @(negedge clk_i);
    while (beats_to_send.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (err_count == 0 && pending_verdicts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
